// ----- sv/tca_pkg.sv -----
// Shared types, codes and constants for the transaction-layer credit and tag allocator.
// Used by every module of the block; it depends on nothing else.
package tca_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int TAG_DEPTH_DEF  = 256;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0]  HDR_CREDIT_MAX = 8'hFF;
  localparam logic [11:0] PAY_CREDIT_MAX = 12'hFFF;
  localparam logic [7:0]  RST_HDR_CREDITS = 8'd32;
  localparam logic [11:0] RST_PAY_CREDITS = 12'd256;
  localparam int          RST_TAG_COUNT   = 32;
  localparam logic [15:0] RST_REQUESTER   = 16'd0;

  localparam logic [2:0] OPC_SUBMIT      = 3'd0;
  localparam logic [2:0] OPC_WRITE       = 3'd1;
  localparam logic [2:0] OPC_READ        = 3'd2;
  localparam logic [2:0] OPC_REL_CREDIT  = 3'd3;
  localparam logic [2:0] OPC_REL_TAG     = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NO_CREDIT = 2'd2;
  localparam logic [1:0] ST_NO_TAG    = 2'd3;

  localparam logic [1:0] CFG_REQUESTER  = 2'd0;
  localparam logic [1:0] CFG_HDR_CREDIT = 2'd1;
  localparam logic [1:0] CFG_PAY_CREDIT = 2'd2;
  localparam logic [1:0] CFG_TAG_COUNT  = 2'd3;

  typedef enum logic [2:0] {
    CMD_SUBMIT,
    CMD_WRITE,
    CMD_READ,
    CMD_REL_CREDIT,
    CMD_REL_TAG,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [7:0]  kind;
    logic [9:0]  count;
    logic [9:0]  index;
    logic [31:0] data;
    logic [7:0]  rtag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [9:0]  length;
    logic [7:0]  kind;
    logic [15:0] requester;
    logic [9:0]  base;
    logic [31:0] rdata;
  } res_t;

endpackage

// ----- sv/tca_fifo.sv -----
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on tca_pkg for its default depth; the payload is a flat vector of W bits.
module tca_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = tca_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- sv/tca_front.sv -----
// Front end: accepts requests, decodes the opcode into a command class and queues them.
// Depends on tca_pkg and tca_fifo.
module tca_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        opcode_i,
  input  logic [7:0]        tlp_kind_i,
  input  logic [9:0]        word_count_i,
  input  logic [9:0]        word_index_i,
  input  logic [31:0]       word_data_i,
  input  logic [7:0]        returned_tag_i,
  output tca_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i
);

  tca_pkg::cmd_t cmd_in;
  logic          q_empty;

  always_comb begin
    cmd_in.kind  = tlp_kind_i;
    cmd_in.count = word_count_i;
    cmd_in.index = word_index_i;
    cmd_in.data  = word_data_i;
    cmd_in.rtag  = returned_tag_i;
    unique case (opcode_i)
      tca_pkg::OPC_SUBMIT:     cmd_in.op = tca_pkg::CMD_SUBMIT;
      tca_pkg::OPC_WRITE:      cmd_in.op = tca_pkg::CMD_WRITE;
      tca_pkg::OPC_READ:       cmd_in.op = tca_pkg::CMD_READ;
      tca_pkg::OPC_REL_CREDIT: cmd_in.op = tca_pkg::CMD_REL_CREDIT;
      tca_pkg::OPC_REL_TAG:    cmd_in.op = tca_pkg::CMD_REL_TAG;
      default:                 cmd_in.op = tca_pkg::CMD_NOP;
    endcase
  end

  tca_fifo #(
    .W     ($bits(tca_pkg::cmd_t)),
    .DEPTH (tca_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;

endmodule

// ----- sv/tca_back.sv -----
// Back end: credit counters, free tag FIFO, payload ring and the two-stage execute pipe.
// Depends on tca_pkg. Ring and tag depths must be powers of two.
module tca_back #(
  parameter int RING_DEPTH = tca_pkg::RING_DEPTH_DEF,
  parameter int TAG_DEPTH  = tca_pkg::TAG_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  tca_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  output tca_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i
);

  localparam int RW   = $clog2(RING_DEPTH);
  localparam int TW   = $clog2(TAG_DEPTH);
  localparam int LW   = TW + 1;
  localparam int CMPW = (RW > 10) ? RW : 10;
  localparam int RST_TAGS = (TAG_DEPTH < tca_pkg::RST_TAG_COUNT) ? TAG_DEPTH
                                                                 : tca_pkg::RST_TAG_COUNT;

  typedef struct packed {
    logic [1:0]    status;
    logic [TW-1:0] tag_idx;
    logic          sel_tag;
    logic          sel_read;
    logic [9:0]    length;
    logic [7:0]    kind;
    logic [15:0]   requester;
    logic [9:0]    base;
  } stage_t;

  logic [15:0]    req_id_q;
  logic [7:0]     hdr_q, hdr_d;
  logic [11:0]    pay_q, pay_d;
  logic [TW-1:0]  trd_q, trd_d, twr_q, twr_d;
  logic [LW-1:0]  tlvl_q, tlvl_d;
  logic [TAG_DEPTH-1:0] tvld_q;
  logic [RW-1:0]  head_q, head_d, tail_q, tail_d;
  stage_t         s2_q, s2_d;
  logic           s2_valid_q;

  logic [7:0]     tag_mem [TAG_DEPTH];
  logic [31:0]    ring_mem [RING_DEPTH];
  logic [7:0]     tag_rdata_q;
  logic           tag_rvld_q;
  logic [31:0]    ring_rdata_q;

  logic           fire, ring_we, ring_re, tag_we, tag_re;
  logic [RW-1:0]  ring_idx, vac;
  logic           space_ok, credit_ok, tag_ok;
  logic [12:0]    pay_sum;
  logic [8:0]     load_n;

  assign res_push_o = s2_valid_q && !res_full_i;
  assign fire       = cmd_valid_i && (!s2_valid_q || !res_full_i);
  assign cmd_pop_o  = fire;
  assign ring_idx   = RW'(cmd_i.index);

  // A submit always leaves one slot of the ring empty.
  assign vac       = head_q - tail_q - 1'b1;
  assign space_ok  = CMPW'(cmd_i.count) <= CMPW'(vac);
  assign credit_ok = (hdr_q != '0) && (12'(cmd_i.count) <= pay_q);
  assign tag_ok    = (tlvl_q != '0);
  assign pay_sum   = 13'(pay_q) + 13'(cmd_i.count);
  assign load_n    = (cfg_data_i[8:0] > 9'(TAG_DEPTH)) ? 9'(TAG_DEPTH) : cfg_data_i[8:0];

  always_comb begin
    hdr_d   = hdr_q;
    pay_d   = pay_q;
    trd_d   = trd_q;
    twr_d   = twr_q;
    tlvl_d  = tlvl_q;
    head_d  = head_q;
    tail_d  = tail_q;
    ring_we = 1'b0;
    ring_re = 1'b0;
    tag_we  = 1'b0;
    tag_re  = 1'b0;
    s2_d    = '0;
    s2_d.tag_idx = trd_q;
    if (fire) begin
      unique case (cmd_i.op)
        tca_pkg::CMD_SUBMIT: begin
          if (!space_ok) begin
            s2_d.status = tca_pkg::ST_NO_SPACE;
          end else if (!credit_ok) begin
            s2_d.status = tca_pkg::ST_NO_CREDIT;
          end else if (!tag_ok) begin
            s2_d.status = tca_pkg::ST_NO_TAG;
          end else begin
            tag_re         = 1'b1;
            s2_d.status    = tca_pkg::ST_OK;
            s2_d.sel_tag   = 1'b1;
            s2_d.length    = cmd_i.count;
            s2_d.kind      = cmd_i.kind;
            s2_d.requester = req_id_q;
            s2_d.base      = 10'(tail_q);
            trd_d  = trd_q + 1'b1;
            tlvl_d = tlvl_q - 1'b1;
            hdr_d  = hdr_q - 1'b1;
            pay_d  = pay_q - 12'(cmd_i.count);
            tail_d = tail_q + RW'(cmd_i.count);
          end
        end
        tca_pkg::CMD_WRITE: ring_we = 1'b1;
        tca_pkg::CMD_READ: begin
          ring_re       = 1'b1;
          s2_d.sel_read = 1'b1;
        end
        tca_pkg::CMD_REL_CREDIT: begin
          hdr_d  = (hdr_q == tca_pkg::HDR_CREDIT_MAX) ? hdr_q : hdr_q + 1'b1;
          pay_d  = (pay_sum > 13'(tca_pkg::PAY_CREDIT_MAX)) ? tca_pkg::PAY_CREDIT_MAX
                                                            : pay_sum[11:0];
          head_d = head_q + RW'(cmd_i.count);
        end
        tca_pkg::CMD_REL_TAG: begin
          if (tlvl_q < LW'(TAG_DEPTH)) begin
            tag_we = 1'b1;
            twr_d  = twr_q + 1'b1;
            tlvl_d = tlvl_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    // The user must write configuration only while the block is idle; the block does not enforce this.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tca_pkg::CFG_HDR_CREDIT: hdr_d = cfg_data_i[7:0];
        tca_pkg::CFG_PAY_CREDIT: pay_d = cfg_data_i[11:0];
        tca_pkg::CFG_TAG_COUNT: begin
          trd_d  = '0;
          twr_d  = TW'(load_n);
          tlvl_d = LW'(load_n);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_id_q   <= tca_pkg::RST_REQUESTER;
      hdr_q      <= tca_pkg::RST_HDR_CREDITS;
      pay_q      <= tca_pkg::RST_PAY_CREDITS;
      trd_q      <= '0;
      twr_q      <= TW'(RST_TAGS);
      tlvl_q     <= LW'(RST_TAGS);
      tvld_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      hdr_q  <= hdr_d;
      pay_q  <= pay_d;
      trd_q  <= trd_d;
      twr_q  <= twr_d;
      tlvl_q <= tlvl_d;
      head_q <= head_d;
      tail_q <= tail_d;
      if (cfg_we_i && cfg_idx_i == tca_pkg::CFG_REQUESTER) begin
        req_id_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == tca_pkg::CFG_TAG_COUNT) begin
        tvld_q <= '0;
      end else if (tag_we) begin
        tvld_q[twr_q] <= 1'b1;
      end
      if (fire) begin
        s2_valid_q <= 1'b1;
      end else if (res_push_o) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s2_q <= s2_d;
    end
    if (ring_we) begin
      ring_mem[ring_idx] <= cmd_i.data;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_idx];
    end
    if (tag_we) begin
      tag_mem[twr_q] <= cmd_i.rtag;
    end
    if (tag_re) begin
      tag_rdata_q <= tag_mem[trd_q];
      tag_rvld_q  <= tvld_q[trd_q];
    end
  end

  // An entry not written since the last load holds its own index.
  always_comb begin
    res_o.status    = s2_q.status;
    res_o.length    = s2_q.length;
    res_o.kind      = s2_q.kind;
    res_o.requester = s2_q.requester;
    res_o.base      = s2_q.base;
    res_o.tag       = !s2_q.sel_tag ? 8'd0 : (tag_rvld_q ? tag_rdata_q : 8'(s2_q.tag_idx));
    res_o.rdata     = s2_q.sel_read ? ring_rdata_q : 32'd0;
  end

endmodule

// ----- sv/tlp_credit_tag_allocator_core.sv -----
// Top level of the transaction-layer credit and tag allocator.
// Depends on tca_pkg, tca_front, tca_back and tca_fifo.
//
// Requests enter through a queue-like port: a request is taken at a clock edge where
// push is high and full is low. Every request produces exactly one result, which
// waits in a result queue; the oldest result is on the result ports while empty is
// low and leaves at an edge where pop is high.
// A submit reserves ring space, one header credit, word_count payload credits and a
// tag, or answers with the first check that failed. Write and read move one payload
// word; release credits also frees ring slots at the head; release tag refills the
// free tag FIFO.
// A request moves from the command queue through the execute stage register into the
// result queue. Throughput: one request per cycle is sustained while the result queue
// has room; the execute stage owns the counters, the tag memory and the ring memory port.
// A two-entry command queue separates the input from the execute stage and a
// two-entry result queue separates it from the output, so when pop is held low the
// pipe fills and full rises; nothing is dropped.
// Reset loads 32 header credits, 256 payload credits, tags 0 to 31 and an empty ring.
// Configuration writes on cfg_we_i take effect at once. Users must make them while idle;
// the block does not enforce it. The ring and tag depths must be powers of two.
module tlp_credit_tag_allocator_core #(
  parameter int RING_DEPTH = tca_pkg::RING_DEPTH_DEF,
  parameter int TAG_DEPTH  = tca_pkg::TAG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  tlp_kind_i,
  input  logic [9:0]  word_count_i,
  input  logic [9:0]  word_index_i,
  input  logic [31:0] word_data_i,
  input  logic [7:0]  returned_tag_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [7:0]  issued_tag_o,
  output logic [9:0]  issued_length_o,
  output logic [7:0]  issued_kind_o,
  output logic [15:0] issued_requester_o,
  output logic [9:0]  buffer_base_o,
  output logic [31:0] read_data_o
);

  tca_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  tca_pkg::res_t res_in, res_out;
  logic          res_push, res_full;

  tca_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .opcode_i       (opcode_i),
    .tlp_kind_i     (tlp_kind_i),
    .word_count_i   (word_count_i),
    .word_index_i   (word_index_i),
    .word_data_i    (word_data_i),
    .returned_tag_i (returned_tag_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_pop_i      (cmd_pop)
  );

  tca_back #(
    .RING_DEPTH (RING_DEPTH),
    .TAG_DEPTH  (TAG_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  tca_fifo #(
    .W     ($bits(tca_pkg::res_t)),
    .DEPTH (tca_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o           = res_out.status;
  assign issued_tag_o       = res_out.tag;
  assign issued_length_o    = res_out.length;
  assign issued_kind_o      = res_out.kind;
  assign issued_requester_o = res_out.requester;
  assign buffer_base_o      = res_out.base;
  assign read_data_o        = res_out.rdata;

endmodule

// ----- tb/tlp_credit_tag_allocator_core_tb.sv -----
// Self-checking testbench for tlp_credit_tag_allocator_core: directed corners, config
// sweeps and random request streams under random idling, checked against a local model.
// Depends on tca_pkg and the RTL of the allocator only.
`timescale 1ns / 1ps

module tlp_credit_tag_allocator_core_tb;

  // Opcodes 5 to 7 are not defined; the block must answer them with an all-zero result.
  localparam logic [2:0] OPC_UNDEF_LO = 3'd5;
  localparam logic [2:0] OPC_UNDEF_HI = 3'd7;
  localparam int RING = 1024;
  localparam int TAGS = 256;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  kind;
    logic [9:0]  count;
    logic [9:0]  index;
    logic [31:0] data;
    logic [7:0]  rtag;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  opcode_i = '0;
  logic [7:0]  tlp_kind_i = '0;
  logic [9:0]  word_count_i = '0;
  logic [9:0]  word_index_i = '0;
  logic [31:0] word_data_i = '0;
  logic [7:0]  returned_tag_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  issued_tag_o;
  logic [9:0]  issued_length_o;
  logic [7:0]  issued_kind_o;
  logic [15:0] issued_requester_o;
  logic [9:0]  buffer_base_o;
  logic [31:0] read_data_o;

  tlp_credit_tag_allocator_core dut (.*);

  always #1 clk_i = ~clk_i;

  // Local copy of the allocator state, advanced once per accepted request.
  logic [15:0] mdl_requester;
  logic [7:0]  mdl_hdr_credits;
  logic [11:0] mdl_pay_credits;
  logic [7:0]  mdl_tag_fifo [TAGS];
  int          mdl_tag_rd, mdl_tag_wr, mdl_tag_level;
  logic [31:0] mdl_ring [RING];
  bit          mdl_written [RING];
  int          mdl_head, mdl_tail;

  // Bookkeeping that lets the random stream hand back what it was granted.
  tca_pkg::res_t expected_results [$];
  logic [7:0]  granted_tags [$];
  int          granted_lengths [$];
  int          written_slots [$];

  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_request = 0;
  int quiet_cycles = 0;

  function automatic void reload_tags(int count);
    int n;
    n = (count > TAGS) ? TAGS : count;
    for (int i = 0; i < TAGS; i++) mdl_tag_fifo[i] = (i < n) ? 8'(i) : 8'd0;
    mdl_tag_rd = 0;
    mdl_tag_wr = n % TAGS;
    mdl_tag_level = n;
    granted_tags.delete();
  endfunction

  // Computes the result of one request and advances the local state.
  function automatic tca_pkg::res_t allocate_and_answer(request_t r);
    tca_pkg::res_t res;
    int   space;
    int   sum;
    res = '0;
    case (r.op)
      tca_pkg::OPC_SUBMIT: begin
        space = (mdl_head + RING - mdl_tail - 1) % RING;
        if (r.count > space) begin
          res.status = tca_pkg::ST_NO_SPACE;
        end else if (mdl_hdr_credits < 1 || r.count > mdl_pay_credits) begin
          res.status = tca_pkg::ST_NO_CREDIT;
        end else if (mdl_tag_level == 0) begin
          res.status = tca_pkg::ST_NO_TAG;
        end else begin
          res.status = tca_pkg::ST_OK;
          res.tag = mdl_tag_fifo[mdl_tag_rd];
          res.length = r.count;
          res.kind = r.kind;
          res.requester = mdl_requester;
          res.base = 10'(mdl_tail);
          mdl_tag_rd = (mdl_tag_rd + 1) % TAGS;
          mdl_tag_level--;
          mdl_hdr_credits = mdl_hdr_credits - 8'd1;
          mdl_pay_credits = mdl_pay_credits - 12'(r.count);
          mdl_tail = (mdl_tail + r.count) % RING;
          granted_tags.push_back(res.tag);
          granted_lengths.push_back(r.count);
        end
      end
      tca_pkg::OPC_WRITE: begin
        mdl_ring[r.index] = r.data;
        if (!mdl_written[r.index]) written_slots.push_back(r.index);
        mdl_written[r.index] = 1'b1;
      end
      tca_pkg::OPC_READ: res.rdata = mdl_ring[r.index];
      tca_pkg::OPC_REL_CREDIT: begin
        sum = mdl_pay_credits + r.count;
        if (mdl_hdr_credits != tca_pkg::HDR_CREDIT_MAX)
          mdl_hdr_credits = mdl_hdr_credits + 8'd1;
        mdl_pay_credits = (sum > tca_pkg::PAY_CREDIT_MAX) ? tca_pkg::PAY_CREDIT_MAX
                                                          : 12'(sum);
        mdl_head = (mdl_head + r.count) % RING;
      end
      tca_pkg::OPC_REL_TAG: begin
        if (mdl_tag_level < TAGS) begin
          mdl_tag_fifo[mdl_tag_wr] = r.rtag;
          mdl_tag_wr = (mdl_tag_wr + 1) % TAGS;
          mdl_tag_level++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic request_t make_request(logic [2:0] op, logic [7:0] kind,
                                            logic [9:0] count, logic [9:0] index,
                                            logic [31:0] data, logic [7:0] rtag);
    request_t r;
    r.op = op;
    r.kind = kind;
    r.count = count;
    r.index = index;
    r.data = data;
    r.rtag = rtag;
    return r;
  endfunction

  // Offers one request starting at a falling edge, optionally after a random gap, and
  // returns at the falling edge after the rising edge that took it.
  task automatic send_request(request_t r);
    if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= r.op;
    tlp_kind_i <= r.kind;
    word_count_i <= r.count;
    word_index_i <= r.index;
    word_data_i <= r.data;
    returned_tag_i <= r.rtag;
    do @(posedge clk_i); while (full);
    expected_results.push_back(allocate_and_answer(r));
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every expected result has been popped, then lets the pipe settle so a
  // config write never overlaps a request still in flight.
  task automatic wait_until_idle();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tca_pkg::CFG_REQUESTER: mdl_requester = value;
      tca_pkg::CFG_HDR_CREDIT: begin
        mdl_hdr_credits = value[7:0];
        granted_lengths.delete();
      end
      tca_pkg::CFG_PAY_CREDIT: begin
        mdl_pay_credits = value[11:0];
        granted_lengths.delete();
      end
      default: reload_tags(int'(value[8:0]));
    endcase
    @(negedge clk_i);
  endtask

  // Small submits dominate so the ring and credits keep turning over; a few use the
  // full length range to reach the space and credit limits.
  function automatic logic [9:0] pick_length();
    return ($urandom_range(99) < 6) ? 10'($urandom_range(0, 1023))
                                    : 10'($urandom_range(0, 15));
  endfunction

  function automatic request_t random_request();
    int       pick;
    int       pos;
    logic [9:0] count;
    logic [7:0] tag;
    request_t r;
    r = make_request(tca_pkg::OPC_SUBMIT, 8'($urandom), pick_length(), 10'($urandom),
                     $urandom, 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.op = tca_pkg::OPC_SUBMIT;
    end else if (pick < 50) begin
      r.op = tca_pkg::OPC_WRITE;
    end else if (pick < 65) begin
      // Reads only touch slots that have been written at least once.
      if (written_slots.size() == 0) begin
        r.op = tca_pkg::OPC_WRITE;
      end else begin
        r.op = tca_pkg::OPC_READ;
        r.index = 10'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
      end
    end else if (pick < 81) begin
      r.op = tca_pkg::OPC_REL_CREDIT;
      if (granted_lengths.size() != 0 && $urandom_range(99) < 80) begin
        count = 10'(granted_lengths.pop_front());
        r.count = count;
      end
    end else if (pick < 97) begin
      r.op = tca_pkg::OPC_REL_TAG;
      if (granted_tags.size() != 0 && $urandom_range(99) < 85) begin
        pos = $urandom_range(0, granted_tags.size() - 1);
        tag = granted_tags[pos];
        granted_tags.delete(pos);
        r.rtag = tag;
      end
    end else begin
      r.op = 3'($urandom_range(OPC_UNDEF_LO, OPC_UNDEF_HI));
    end
    return r;
  endfunction

  // Receiver: pops at random, or holds off entirely while a long stall is running.
  always @(negedge clk_i) begin
    static int hold_left = 0;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_ni || hold_left > 0) begin
      pop <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else begin
      pop <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               results_seen, name, exp_v, act_v);
  endtask

  // Every popped result is checked, field by field, against the oldest expectation.
  always @(posedge clk_i) begin
    tca_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) report_field("status", want.status, status_o);
        if (issued_tag_o !== want.tag) report_field("tag", want.tag, issued_tag_o);
        if (issued_length_o !== want.length)
          report_field("length", want.length, issued_length_o);
        if (issued_kind_o !== want.kind) report_field("kind", want.kind, issued_kind_o);
        if (issued_requester_o !== want.requester)
          report_field("requester", want.requester, issued_requester_o);
        if (buffer_base_o !== want.base) report_field("base", want.base, buffer_base_o);
        if (read_data_o !== want.rdata) report_field("read data", want.rdata, read_data_o);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any request or result moving means the block hung.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Basic operations from the reset state, plus the ring space, credit saturation,
  // over-release and undefined opcode corners.
  task automatic test_directed();
    send_request(make_request(tca_pkg::OPC_WRITE, 8'h00, 10'd0, 10'd0, 32'hFFFF_FFFF, 8'h00));
    send_request(make_request(tca_pkg::OPC_WRITE, 8'hFF, 10'd0, 10'd1023, 32'h0, 8'hFF));
    send_request(make_request(tca_pkg::OPC_READ, 8'h00, 10'd0, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_READ, 8'h00, 10'd0, 10'd1023, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h00, 10'd0, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'hFF, 10'd200, 10'd0, 32'h0, 8'h00));
    // The ring now lacks room for a maximal submit.
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h5A, 10'd1023, 10'd0, 32'h0, 8'h00));
    // Room is there but payload credits are not.
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'hA5, 10'd700, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_REL_TAG, 8'h00, 10'd0, 10'd0, 32'h0, 8'hFF));
    send_request(make_request(tca_pkg::OPC_REL_TAG, 8'h00, 10'd0, 10'd0, 32'h0, 8'h00));
    // Releasing far more than was reserved saturates payload credits and moves the
    // head past the tail.
    repeat (4)
      send_request(make_request(tca_pkg::OPC_REL_CREDIT, 8'h00, 10'd1023, 10'd0, 32'h0,
                                8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h3C, 10'd5, 10'd0, 32'h0, 8'h00));
    for (logic [3:0] op = 4'(OPC_UNDEF_LO); op <= 4'(OPC_UNDEF_HI); op++)
      send_request(make_request(op[2:0], 8'hFF, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 8'hFF));
    stop_sending();
    wait_until_idle();
  endtask

  // Each register at its extremes, with requests that expose the new setting.
  task automatic test_config_corners();
    write_register(tca_pkg::CFG_REQUESTER, 16'hFFFF);
    write_register(tca_pkg::CFG_HDR_CREDIT, 16'd0);
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h11, 10'd0, 10'd0, 32'h0, 8'h00));
    stop_sending();
    wait_until_idle();
    write_register(tca_pkg::CFG_HDR_CREDIT, 16'd255);
    write_register(tca_pkg::CFG_PAY_CREDIT, 16'd0);
    send_request(make_request(tca_pkg::OPC_REL_CREDIT, 8'h00, 10'd0, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h22, 10'd1, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h23, 10'd0, 10'd0, 32'h0, 8'h00));
    stop_sending();
    wait_until_idle();
    write_register(tca_pkg::CFG_PAY_CREDIT, 16'd4095);
    write_register(tca_pkg::CFG_TAG_COUNT, 16'd0);
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h33, 10'd2, 10'd0, 32'h0, 8'h00));
    stop_sending();
    wait_until_idle();
    // A count beyond the tag depth is clipped; a full FIFO ignores a returned tag.
    write_register(tca_pkg::CFG_TAG_COUNT, 16'd511);
    send_request(make_request(tca_pkg::OPC_REL_TAG, 8'h00, 10'd0, 10'd0, 32'h0, 8'h7E));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h44, 10'd3, 10'd0, 32'h0, 8'h00));
    stop_sending();
    wait_until_idle();
    write_register(tca_pkg::CFG_TAG_COUNT, 16'd1);
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h55, 10'd1, 10'd0, 32'h0, 8'h00));
    send_request(make_request(tca_pkg::OPC_SUBMIT, 8'h56, 10'd1, 10'd0, 32'h0, 8'h00));
    stop_sending();
    wait_until_idle();
    write_register(tca_pkg::CFG_TAG_COUNT, 16'd256);
    write_register(tca_pkg::CFG_REQUESTER, 16'h0000);
  endtask

  // One random phase under a fresh random configuration.
  task automatic test_random_phase(int n, int sender_idle, int receiver_stall);
    write_register(tca_pkg::CFG_REQUESTER, 16'($urandom));
    write_register(tca_pkg::CFG_HDR_CREDIT, 16'($urandom_range(16, 255)));
    write_register(tca_pkg::CFG_PAY_CREDIT, 16'($urandom_range(64, 4095)));
    write_register(tca_pkg::CFG_TAG_COUNT, 16'($urandom_range(1, 256)));
    snd_idle = sender_idle;
    rcv_stall = receiver_stall;
    for (int i = 0; i < n; i++) send_request(random_request());
    stop_sending();
    wait_until_idle();
    snd_idle = 0;
    rcv_stall = 0;
  endtask

  // The receiver stops for a long stretch while requests keep coming, so both queues
  // fill and full must hold the sender off; then the sender waits for a full drain.
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_request = 80;
    @(negedge clk_i);
    for (int i = 0; i < 25; i++) send_request(random_request());
    stop_sending();
    wait_until_idle();
    for (int i = 0; i < 10; i++) send_request(random_request());
    stop_sending();
    wait_until_idle();
  endtask

  initial begin
    mdl_requester = tca_pkg::RST_REQUESTER;
    mdl_hdr_credits = tca_pkg::RST_HDR_CREDITS;
    mdl_pay_credits = tca_pkg::RST_PAY_CREDITS;
    reload_tags(tca_pkg::RST_TAG_COUNT);
    mdl_head = 0;
    mdl_tail = 0;
    for (int i = 0; i < RING; i++) begin
      mdl_ring[i] = '0;
      mdl_written[i] = 1'b0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_config_corners();
    test_random_phase(380, 0, 0);
    test_random_phase(380, 66, 0);
    test_random_phase(380, 0, 66);
    test_random_phase(380, 23, 23);
    test_backpressure();

    $display("covered %0d requests and %0d results: all opcodes, status codes, config",
             requests_sent, results_seen);
    $display("extremes, random idling on both sides and a long receiver stall");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
